>>> hw/rtl/cht_pkg.sv
// Package: command, status and config codes, reset values, request, response, entry and store-control types.
`timescale 1ns / 1ps

package cht_pkg;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_LOOKUP = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_HANDLE = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_REFUSED   = 2'd3;

    localparam logic CFG_HANDLE_BASE = 1'b0;
    localparam logic CFG_MAX_CHUNKS  = 1'b1;

    localparam logic [31:0] HANDLE_BASE_RST = 32'd1;
    localparam logic [4:0]  MAX_CHUNKS_RST  = 5'd16;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] object_value;
        logic [31:0] context_tag;
        logic [31:0] handle_in;
        logic        retain_refused;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] handle_out;
        logic [31:0] object_out;
    } t_rsp;

    typedef struct packed {
        logic        alloc;
        logic [31:0] ctx;
        logic [31:0] obj;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic ent_we;
        logic link_we;
    } t_store_ctl;

endpackage

>>> hw/rtl/cht_store.sv
// Entry memory (flag, context, object) and free-list link memory.
`timescale 1ns / 1ps

module cht_store
    import cht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int IW          = 10
) (
    input  logic          i_clk,
    input  t_store_ctl    i_ctl,
    input  logic [IW-1:0] i_ent_raddr,
    input  logic [IW-1:0] i_ent_waddr,
    input  t_entry        i_ent_wdata,
    output t_entry        o_ent_rdata,
    input  logic [IW-1:0] i_link_raddr,
    input  logic [IW-1:0] i_link_waddr,
    input  logic [IW-1:0] i_link_wdata,
    output logic [IW-1:0] o_link_rdata
);

    t_entry      r_ent_mem  [TABLE_DEPTH];
    logic [IW-1:0] r_link_mem [TABLE_DEPTH];
    t_entry      r_ent_rd;
    logic [IW-1:0] r_link_rd;

    always_ff @(posedge i_clk) begin
        if (i_ctl.ent_we) begin
            r_ent_mem[i_ent_waddr] <= i_ent_wdata;
        end
        if (i_ctl.rd_en) begin
            r_ent_rd <= r_ent_mem[i_ent_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.link_we) begin
            r_link_mem[i_link_waddr] <= i_link_wdata;
        end
        if (i_ctl.rd_en) begin
            r_link_rd <= r_link_mem[i_link_raddr];
        end
    end

    assign o_ent_rdata  = r_ent_rd;
    assign o_link_rdata = r_link_rd;

endmodule

>>> hw/rtl/context_handle_table.sv
// Top level: handle table with FIFO free list, alloc / lookup / free requests.
//
// Usage: requests enter on i_in_valid / o_in_ready with a t_req payload and
// answers leave on o_out_valid / i_out_ready with a t_rsp payload, one
// answer per request, in order. Configuration (handle_base, max_chunks) is
// written on i_cfg_valid / o_cfg_ready; the user must write it only while
// no request is in flight, as the block itself does not enforce this.
// The accept in S_IDLE reads the entry memory and the free-list link memory;
// S_EXEC then checks, writes back and loads the output register. This single
// read-then-write pass admits no new request until S_EXEC is left.
// The output register holds an answer while the receiver stalls; one more
// request is accepted and waits in execute until the register frees.
// Reset clears the list pointers and counters; no clearing pass is needed,
// since an entry is only treated as allocated when its index is below the
// count of entries ever handed out.
`timescale 1ns / 1ps

module context_handle_table
    import cht_pkg::*;
#(
    parameter int TABLE_DEPTH   = 1024,
    parameter int CHUNK_ENTRIES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_req,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_rsp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CHK_W = $clog2(CHUNK_ENTRIES + 1);
    localparam int CAP_W = 5 + CHK_W;
    localparam int SW    = (CNT_W > CAP_W) ? CNT_W + 1 : CAP_W + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic [31:0] r_base;
    logic [4:0]  r_max_chunks;
    t_req        r_req;
    logic [31:0] r_rel;
    logic [IW-1:0] r_head, n_head;
    logic [IW-1:0] r_tail, n_tail;
    logic          r_empty, n_empty;
    logic [CNT_W-1:0] r_fresh, n_fresh;
    logic [CNT_W-1:0] r_limit, n_limit;
    logic r_out_valid;
    t_rsp r_out, n_out;

    t_store_ctl    ctl;
    t_entry        ent_rd, ent_wr;
    logic [IW-1:0] ent_waddr;
    logic [IW-1:0] link_rd;
    logic [31:0]   in_rel;

    logic          accept, can_load;
    logic [SW-1:0] w_limit, w_cap, w_sum;
    logic          need_grow, can_grow, use_fresh, found;
    logic [IW-1:0] alloc_idx, rel_idx;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign can_load    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign in_rel      = i_in_req.handle_in - r_base;

    cht_store #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .IW         (IW)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_ent_raddr (in_rel[IW-1:0]),
        .i_ent_waddr (ent_waddr),
        .i_ent_wdata (ent_wr),
        .o_ent_rdata (ent_rd),
        .i_link_raddr(r_head),
        .i_link_waddr(r_tail),
        .i_link_wdata(rel_idx),
        .o_link_rdata(link_rd)
    );

    // growth check
    assign w_limit   = SW'(r_limit);
    assign w_cap     = SW'(r_max_chunks) * SW'(CHUNK_ENTRIES);
    assign w_sum     = w_limit + SW'(CHUNK_ENTRIES);
    assign need_grow = (r_fresh >= r_limit) && r_empty;
    assign can_grow  = (w_limit < w_cap) && (w_sum <= SW'(TABLE_DEPTH));
    assign use_fresh = (r_fresh < r_limit) || need_grow;
    assign alloc_idx = use_fresh ? r_fresh[IW-1:0] : r_head;

    // lookup / free check; entries at or above r_fresh were never allocated
    assign rel_idx = r_rel[IW-1:0];
    assign found   = (r_rel < 32'(r_fresh)) && ent_rd.alloc
                     && (ent_rd.ctx == r_req.context_tag);

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_tail    = r_tail;
        n_empty   = r_empty;
        n_fresh   = r_fresh;
        n_limit   = r_limit;
        n_out     = r_out;
        ctl       = '0;
        ent_waddr = rel_idx;
        ent_wr    = ent_rd;
        ctl.rd_en = accept;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_load) begin
                    n_state = S_IDLE;
                    n_out   = '{status: ST_NOT_FOUND, handle_out: '0, object_out: '0};
                    case (r_req.command)
                        CMD_ALLOC: begin
                            if (need_grow && !can_grow) begin
                                n_out.status     = ST_NO_HANDLE;
                                n_out.handle_out = r_base - 32'd1;
                            end else begin
                                if (need_grow) begin
                                    n_limit = w_sum[CNT_W-1:0];
                                end
                                if (use_fresh) begin
                                    n_fresh = r_fresh + CNT_W'(1);
                                end else if (r_head == r_tail) begin
                                    n_empty = 1'b1;
                                end else begin
                                    n_head = link_rd;
                                end
                                ctl.ent_we       = 1'b1;
                                ent_waddr        = alloc_idx;
                                ent_wr.alloc     = 1'b1;
                                ent_wr.ctx       = r_req.context_tag;
                                ent_wr.obj       = r_req.object_value;
                                n_out.status     = ST_OK;
                                n_out.handle_out = 32'(alloc_idx) + r_base;
                            end
                        end
                        CMD_LOOKUP, CMD_FREE: begin
                            if (found && r_req.retain_refused) begin
                                n_out.status = ST_REFUSED;
                            end else if (found) begin
                                n_out.status     = ST_OK;
                                n_out.object_out = ent_rd.obj;
                                if (r_req.command == CMD_FREE) begin
                                    ctl.ent_we   = 1'b1;
                                    ent_wr.alloc = 1'b0;
                                    n_tail       = rel_idx;
                                    if (r_empty) begin
                                        n_head  = rel_idx;
                                        n_empty = 1'b0;
                                    end else begin
                                        ctl.link_we = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_base       <= HANDLE_BASE_RST;
            r_max_chunks <= MAX_CHUNKS_RST;
            r_head       <= '0;
            r_tail       <= '0;
            r_empty      <= 1'b1;
            r_fresh      <= '0;
            r_limit      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_fresh <= n_fresh;
            r_limit <= n_limit;
            if (r_state == S_EXEC && can_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_HANDLE_BASE: r_base       <= i_cfg_data;
                    CFG_MAX_CHUNKS:  r_max_chunks <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_in_req;
            r_rel <= in_rel;
        end
        r_out <= n_out;
    end

endmodule
